FILE: rtl/rgbe_rle_pkg.sv
// ----------------------------------------------------------------------------
// RGBE scanline RLE decoder package
// Shared types, codes and the float32 channel conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbe_rle_pkg;

    localparam int COL_W      = 13;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 12;
    localparam int FLT_W      = 32;
    localparam int TDATA_W    = 208;
    localparam int TUSER_W    = 3;
    localparam logic [7:0] HDR_MAGIC = 8'd2;
    localparam logic [7:0] RUN_BIAS  = 8'd128;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_HDR  = 2'd1,
        ST_WIDTH    = 2'd2,
        ST_OVERRUN  = 2'd3
    } t_status;

    typedef struct packed {
        logic              wr_en;
        logic [1:0]        plane;
        logic [COL_W-1:0]  col;
        logic [BYTE_W-1:0] value;
        logic              rd_en;
        logic              second;
        logic              last;
        logic              err;
        t_status           code;
    } t_cmd;

    typedef struct packed {
        logic room;
    } t_dp_status;

    // Exact float32 bits of m * 2^(e-136), subnormals kept.
    function automatic logic [31:0] chan_bits(input logic [7:0] m, input logic [7:0] e);
        logic [2:0]  p;
        logic [9:0]  biased;
        logic [31:0] mw;
        logic [31:0] res;
        p = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (m[i]) p = 3'(i);
        end
        biased = 10'(p) + 10'(e) - 10'd9;
        mw = 32'(m);
        if (m == 8'd0) begin
            res = 32'd0;
        end else if (!biased[9] && biased != 10'd0) begin
            res = {1'b0, biased[7:0], 23'(mw << (5'd23 - 5'(p)))};
        end else begin
            res = mw << (5'(e) + 5'd13);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rgbe_rle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbe_rle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rgbe_rle_ctl.sv
// ----------------------------------------------------------------------------
// RGBE RLE controller
// Parses the header and run codes and issues store and emit commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbe_rle_ctl #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [7:0]                       i_data,
    input  wire logic [rgbe_rle_pkg::COL_W-1:0]   i_width,
    input  wire rgbe_rle_pkg::t_dp_status         i_stat,
    output logic                                  o_ready,
    output rgbe_rle_pkg::t_cmd                    o_cmd
);
    import rgbe_rle_pkg::*;

    typedef enum logic [2:0] {
        S_HDR0, S_HDR1, S_HDR2, S_HDR3, S_COUNT, S_DATA, S_REP
    } t_state;

    t_state           r_state, n_state;
    logic [23:0]      r_hdr, n_hdr;
    logic [1:0]       r_plane, n_plane;
    logic [7:0]       r_run, n_run;
    logic             r_rep, n_rep;
    logic [COL_W-1:0] r_col, n_col;
    logic [7:0]       r_val, n_val;

    logic             accept;
    logic [7:0]       k;
    logic [14:0]      len;
    logic             bad_hdr;
    logic             bad_len;
    logic [7:0]       step;
    logic [COL_W-1:0] col_next;
    logic             act;

    always_comb begin
        unique case (r_state)
            S_HDR0, S_HDR1, S_HDR2: o_ready = 1'b1;
            S_HDR3, S_COUNT:        o_ready = i_stat.room;
            S_DATA:                 o_ready = (r_plane == 2'd3 && !r_rep) ? i_stat.room : 1'b1;
            default:                o_ready = 1'b0;
        endcase
    end

    assign accept  = i_valid && o_ready;
    assign k       = (i_data > RUN_BIAS) ? i_data - RUN_BIAS : i_data;
    assign len     = {r_hdr[6:0], i_data};
    assign bad_hdr = r_hdr[23:16] != HDR_MAGIC || r_hdr[15:8] != HDR_MAGIC || r_hdr[7];
    assign bad_len = i_width == '0 || 32'(i_width) > MAX_WIDTH || {2'b00, i_width} != len;
    assign step    = (r_state == S_REP && r_run >= 8'd2 && r_plane == 2'd3) ? 8'd2 : 8'd1;
    assign col_next = r_col + COL_W'(step);
    assign act     = r_state == S_REP && (r_plane != 2'd3 || i_stat.room);

    always_comb begin
        n_state = r_state;
        n_hdr   = r_hdr;
        n_plane = r_plane;
        n_run   = r_run;
        n_rep   = r_rep;
        n_col   = r_col;
        n_val   = r_val;
        o_cmd   = '0;
        o_cmd.col = r_col;
        unique case (r_state)
            S_HDR0, S_HDR1, S_HDR2: begin
                if (accept) begin
                    n_hdr = {r_hdr[15:0], i_data};
                    n_state = (r_state == S_HDR0) ? S_HDR1 :
                              (r_state == S_HDR1) ? S_HDR2 : S_HDR3;
                end
            end
            S_HDR3: begin
                if (accept) begin
                    if (bad_hdr || bad_len) begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.err   = 1'b1;
                        o_cmd.code  = bad_hdr ? ST_BAD_HDR : ST_WIDTH;
                        n_state = S_HDR0;
                        n_hdr   = '0;
                    end else begin
                        n_state = S_COUNT;
                        n_plane = 2'd0;
                        n_col   = '0;
                        n_run   = '0;
                        n_rep   = 1'b0;
                    end
                end
            end
            S_COUNT: begin
                if (accept && i_data != 8'd0) begin
                    if (COL_W'(k) > i_width - r_col) begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.err   = 1'b1;
                        o_cmd.code  = ST_OVERRUN;
                        n_state = S_HDR0;
                        n_hdr   = '0;
                        n_plane = 2'd0;
                        n_col   = '0;
                        n_run   = '0;
                        n_rep   = 1'b0;
                    end else begin
                        n_rep   = i_data > RUN_BIAS;
                        n_run   = k;
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (accept) begin
                    if (r_rep) begin
                        n_val   = i_data;
                        n_state = S_REP;
                    end else begin
                        o_cmd.value = i_data;
                        o_cmd.plane = r_plane;
                        if (r_plane == 2'd3) begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.last  = col_next >= i_width;
                        end else begin
                            o_cmd.wr_en = 1'b1;
                        end
                        n_run = r_run - 8'd1;
                        n_col = col_next;
                        if (r_run == 8'd1) n_state = S_COUNT;
                        if (col_next >= i_width) begin
                            n_col = '0;
                            if (r_plane == 2'd3) begin
                                n_state = S_HDR0;
                                n_hdr   = '0;
                                n_plane = 2'd0;
                                n_run   = '0;
                                n_rep   = 1'b0;
                            end else begin
                                n_plane = r_plane + 2'd1;
                            end
                        end
                    end
                end
            end
            default: begin
                o_cmd.value  = r_val;
                o_cmd.plane  = r_plane;
                o_cmd.second = step == 8'd2;
                o_cmd.last   = col_next >= i_width;
                if (act) begin
                    o_cmd.wr_en = r_plane != 2'd3;
                    o_cmd.rd_en = r_plane == 2'd3;
                    n_run = r_run - step;
                    n_col = col_next;
                    if (r_run == step) begin
                        n_state = S_COUNT;
                        n_rep   = 1'b0;
                        if (col_next >= i_width) begin
                            n_col = '0;
                            if (r_plane == 2'd3) begin
                                n_state = S_HDR0;
                                n_hdr   = '0;
                                n_plane = 2'd0;
                            end else begin
                                n_plane = r_plane + 2'd1;
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR0;
            r_hdr   <= '0;
            r_plane <= '0;
            r_run   <= '0;
            r_rep   <= 1'b0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_hdr   <= n_hdr;
            r_plane <= n_plane;
            r_run   <= n_run;
            r_rep   <= n_rep;
            r_col   <= n_col;
        end
        r_val <= n_val;
    end

endmodule

`default_nettype wire

FILE: rtl/rgbe_rle_dp.sv
// ----------------------------------------------------------------------------
// RGBE RLE datapath
// Mantissa planes in RAM, float32 conversion and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbe_rle_dp #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rgbe_rle_pkg::t_cmd                 i_cmd,
    output rgbe_rle_pkg::t_dp_status                o_stat,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [rgbe_rle_pkg::TDATA_W-1:0]        o_data,
    output logic [rgbe_rle_pkg::TUSER_W-1:0]        o_user,
    output logic                                    o_last
);
    import rgbe_rle_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [7:0]       ra [3];
    logic [7:0]       rb [3];
    logic [AW-1:0]    addr_a;
    logic [AW-1:0]    addr_b;

    logic             r_s1_valid;
    logic             r_s1_err;
    t_status          r_s1_code;
    logic [7:0]       r_s1_e;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_sv;
    logic             r_s1_last;
    logic             s1_move;

    logic [TDATA_W-1:0] n_data;
    logic [TUSER_W-1:0] n_user;
    logic [FLT_W-1:0]   px [6];

    assign addr_a = AW'(i_cmd.col);
    assign addr_b = AW'(i_cmd.col + COL_W'(1));

    for (genvar p = 0; p < 3; p++) begin : g_plane
        rgbe_rle_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram (
            .i_clk     (i_clk),
            .i_we      (i_cmd.wr_en && i_cmd.plane == 2'(p)),
            .i_waddr   (addr_a),
            .i_wdata   (i_cmd.value),
            .i_re      (i_cmd.rd_en),
            .i_raddr_a (addr_a),
            .i_raddr_b (addr_b),
            .o_rdata_a (ra[p]),
            .o_rdata_b (rb[p])
        );
    end

    assign s1_move     = r_s1_valid && (!o_valid || i_ready);
    assign o_stat.room = !r_s1_valid || s1_move;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            px[p]     = chan_bits(ra[p], r_s1_e);
            px[p + 3] = r_s1_sv ? chan_bits(rb[p], r_s1_e) : '0;
        end
        if (r_s1_err) begin
            n_data = '0;
            n_user = {r_s1_code, 1'b0};
        end else begin
            n_data = {4'b0, px[5], px[4], px[3], px[2], px[1], px[0], r_s1_idx};
            n_user = {ST_OK, r_s1_sv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (i_cmd.rd_en) r_s1_valid <= 1'b1;
            else if (s1_move) r_s1_valid <= 1'b0;
            if (s1_move) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
        if (i_cmd.rd_en) begin
            r_s1_err  <= i_cmd.err;
            r_s1_code <= i_cmd.code;
            r_s1_e    <= i_cmd.value;
            r_s1_idx  <= i_cmd.col[IDX_W-1:0];
            r_s1_sv   <= i_cmd.second;
            r_s1_last <= i_cmd.last;
        end
        if (s1_move) begin
            o_data <= n_data;
            o_user <= n_user;
            o_last <= r_s1_err || r_s1_last;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rgbe_scanline_rle_decoder_unit.sv
// ----------------------------------------------------------------------------
// RGBE scanline RLE decoder
// Decodes adaptive run-length RGBE scanlines into float32 pixel pairs.
//
// Channel   Direction  Content
// s_axis    in         one stream byte per beat
// m_axis    out        one or two pixels, status and end-of-row per beat
// apb       in/out     image_width at address 0
//
// The last header byte, count bytes and exponent-plane literals wait for room
// in the result stage; no byte is taken while a repeat run is played out. A
// repeat run of k makes k RAM writes on a mantissa plane and ceil(k/2)
// emits of two RAM reads each on the exponent plane. Results pass through a
// one-deep stage and an output register; a stalled output stops issue,
// never drops a beat. Reset is synchronous; the mantissa RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbe_scanline_rle_decoder_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // data_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // first_index, first_red, first_green, first_blue,
    // second_red, second_green, second_blue, zero fill
    output logic [207:0]      m_axis_tdata,
    output logic [2:0]        m_axis_tuser,   // second_valid, status
    output logic              m_axis_tlast,   // row_done
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rgbe_rle_pkg::*;

    logic [COL_W-1:0] r_width;
    t_cmd             cmd;
    t_dp_status       stat;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= COL_W'(1);
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_width <= pwdata[COL_W-1:0];
        end
    end

    rgbe_rle_ctl #(.MAX_WIDTH(MAX_WIDTH)) u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_width (r_width),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    rgbe_rle_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    a_err_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != ST_OK |-> m_axis_tlast)
        else $error("error beat without end of row");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != ST_OK |-> !m_axis_tuser[0])
        else $error("error beat carries a second pixel");

    a_no_cmd_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_en && cmd.rd_en))
        else $error("store and emit issued together");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

FILE: dv/rgbe_scanline_rle_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// RGBE scanline RLE decoder unit test
// Feeds header, run-length planes and malformed streams through the stream
// input, keeps a bit-exact software decoder of the byte stream, and compares
// every output beat with the oldest expected pixel pair, under several
// image widths and idle patterns on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

import rgbe_rle_pkg::*;

typedef struct {
    logic [11:0] index;
    logic [31:0] pix [6];
    logic        pair;
    logic [1:0]  status;
    logic        done;
} pixel_beat_t;

class rgbe_row_decoder;
    localparam int MAXW      = 4096;
    localparam int PH_HDR0   = 0;
    localparam int PH_HDR3   = 3;
    localparam int PH_COUNT  = 4;
    localparam int PH_DATA   = 5;

    int          width = 1;
    int          phase;
    logic [23:0] hdr;
    int          plane;
    int          run_left;
    bit          is_repeat;
    int          column;
    logic [23:0] mant [MAXW];
    pixel_beat_t pending_beats [$];
    int          errors;

    function void restart();
        phase = PH_HDR0;
        hdr = '0;
        plane = 0;
        run_left = 0;
        is_repeat = 0;
        column = 0;
    endfunction

    function logic [31:0] to_float(logic [7:0] m, logic [7:0] e);
        int p;
        int biased;
        logic [31:0] mw;
        p = 0;
        mw = 32'(m);
        if (m == 0) return 32'd0;
        for (int i = 1; i < 8; i++) if (m[i]) p = i;
        biased = p + int'(e) - 9;
        if (biased >= 1) return {1'b0, 8'(biased), 23'(mw << (23 - p))};
        return mw << (int'(e) + 13);
    endfunction

    function void error_beat(logic [1:0] code);
        pixel_beat_t b;
        b.index = '0;
        foreach (b.pix[i]) b.pix[i] = '0;
        b.pair = 0;
        b.status = code;
        b.done = 1;
        pending_beats.push_back(b);
        restart();
    endfunction

    function void place(logic [7:0] v, int k);
        int start;
        pixel_beat_t b;
        logic [23:0] w;
        start = column;
        if (plane < 3) begin
            for (int i = 0; i < k; i++) mant[(start + i) % MAXW][plane*8 +: 8] = v;
            column = start + k;
            if (column >= width) begin
                plane++;
                column = 0;
            end
            return;
        end
        for (int i = 0; i < k; i += 2) begin
            b.index = 12'(start + i);
            foreach (b.pix[j]) b.pix[j] = '0;
            w = mant[(start + i) % MAXW];
            for (int c = 0; c < 3; c++) b.pix[c] = to_float(w[c*8 +: 8], v);
            b.pair = 0;
            if (i + 1 < k) begin
                w = mant[(start + i + 1) % MAXW];
                for (int c = 0; c < 3; c++) b.pix[3+c] = to_float(w[c*8 +: 8], v);
                b.pair = 1;
            end
            b.status = ST_OK;
            b.done = 0;
            pending_beats.push_back(b);
        end
        column = start + k;
        if (column >= width) begin
            pending_beats[$].done = 1;
            restart();
        end
    endfunction

    function void note_byte(logic [7:0] d);
        int k;
        int len;
        if (phase < PH_HDR3) begin
            hdr = {hdr[15:0], d};
            phase++;
        end else if (phase == PH_HDR3) begin
            len = int'(hdr[7:0]) * 256 + int'(d);
            if (hdr[23:16] != HDR_MAGIC || hdr[15:8] != HDR_MAGIC || hdr[7:0] >= 128)
                error_beat(ST_BAD_HDR);
            else if (width < 1 || width > MAXW || len != width)
                error_beat(ST_WIDTH);
            else begin
                plane = 0;
                column = 0;
                run_left = 0;
                is_repeat = 0;
                phase = PH_COUNT;
            end
        end else if (phase == PH_COUNT) begin
            if (d != 0) begin
                is_repeat = d > RUN_BIAS;
                k = is_repeat ? int'(d) - 128 : int'(d);
                if (k > width - column) error_beat(ST_OVERRUN);
                else begin
                    run_left = k;
                    phase = PH_DATA;
                end
            end
        end else begin
            k = is_repeat ? run_left : 1;
            if (is_repeat) run_left = 0;
            else run_left--;
            if (run_left == 0) phase = PH_COUNT;
            place(d, k);
        end
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    function void check_beat(logic [207:0] data, logic [2:0] user, logic last);
        pixel_beat_t b;
        if (pending_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none actual %h", $time, data);
            return;
        end
        b = pending_beats.pop_front();
        compare("first_index", 32'(b.index), 32'(data[11:0]));
        for (int i = 0; i < 6; i++)
            compare($sformatf("pixel word %0d", i), b.pix[i], data[12 + 32*i +: 32]);
        compare("zero fill", 32'd0, 32'(data[207:204]));
        compare("second_valid", 32'(b.pair), 32'(user[0]));
        compare("status", 32'(b.status), 32'(user[2:1]));
        compare("row_done", 32'(b.done), 32'(last));
    endfunction
endclass

module rgbe_scanline_rle_decoder_unit_test;
    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [207:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    localparam logic [2:0] ADDR_IMAGE_WIDTH = 3'd0;

    rgbe_row_decoder decoder = new();
    int              send_idle;
    int              recv_stall;
    logic [7:0]      stream [$];

    rgbe_scanline_rle_decoder_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            decoder.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        m_axis_tready <= $urandom_range(99) >= recv_stall;
    end

    task automatic push_byte(logic [7:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decoder.note_byte(d);
    endtask

    task automatic send_stream();
        while (stream.size() > 0) push_byte(stream.pop_front());
    endtask

    task automatic add_header(int len);
        stream.push_back(HDR_MAGIC);
        stream.push_back(HDR_MAGIC);
        stream.push_back(8'(len >> 8));
        stream.push_back(8'(len));
    endtask

    function automatic logic [7:0] rand_value();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One well-formed row; long_runs makes every run a repeat of the greatest length that fits.
    task automatic add_row(int w, bit long_runs);
        int col;
        int k;
        add_header(w);
        for (int p = 0; p < 4; p++) begin
            col = 0;
            while (col < w) begin
                if ($urandom_range(9) == 0) stream.push_back(8'd0);
                if (long_runs || $urandom_range(1)) begin
                    k = long_runs ? ((w - col < 127) ? w - col : 127)
                                  : $urandom_range((w - col < 127) ? w - col : 127, 1);
                    stream.push_back(8'(128 + k));
                    stream.push_back(rand_value());
                end else begin
                    k = $urandom_range((w - col < 128) ? w - col : 128, 1);
                    stream.push_back(8'(k));
                    repeat (k) stream.push_back(rand_value());
                end
                col += k;
            end
        end
    endtask

    task automatic add_noise(int w);
        int cut;
        case ($urandom_range(4))
            0: begin
                add_header(w);
                stream[$ - 3] = 8'($urandom_range(255, 3));
            end
            1: begin
                stream.push_back(HDR_MAGIC);
                stream.push_back(HDR_MAGIC);
                stream.push_back(8'($urandom_range(255, 128)));
                stream.push_back(8'($urandom));
            end
            2: add_header((w + $urandom_range(50, 1)) & 16'h7FFF);
            3: begin
                add_header(w);
                if (w < 127) stream.push_back(8'(129 + w));
                else stream.push_back(8'hFF);
            end
            default: begin
                add_row(w, 0);
                cut = $urandom_range(stream.size() - 1, 1);
                while (stream.size() > cut) void'(stream.pop_back());
                repeat ($urandom_range(6, 1)) stream.push_back(8'($urandom));
            end
        endcase
    endtask

    // Drives the decoder back to the header state with long repeat counts.
    task automatic flush_row();
        while (decoder.phase != 0) push_byte(8'hFF);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (decoder.pending_beats.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_width(int w);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_IMAGE_WIDTH;
        pwdata <= 32'(w);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        decoder.width = w & 16'h1FFF;
    endtask

    task automatic set_idle(int mode);
        case (mode % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 83; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 83; end
            default: begin send_idle = 6; recv_stall = 6; end
        endcase
    endtask

    task automatic directed();
        // Width one: plain rows, value extremes, zero count, then each error.
        add_header(1);
        stream.push_back(8'd1); stream.push_back(8'hFF);
        stream.push_back(8'd0);
        stream.push_back(8'd1); stream.push_back(8'h00);
        stream.push_back(8'd129); stream.push_back(8'h01);
        stream.push_back(8'd1); stream.push_back(8'h00);
        add_header(1);
        stream.push_back(8'd129); stream.push_back(8'hFF);
        stream.push_back(8'd129); stream.push_back(8'h80);
        stream.push_back(8'd1); stream.push_back(8'h01);
        stream.push_back(8'd129); stream.push_back(8'hFF);
        stream.push_back(8'h03); stream.push_back(8'h02);
        stream.push_back(8'h00); stream.push_back(8'h01);
        add_header(2);
        add_header(1);
        stream.push_back(8'd2);
        send_stream();
    endtask

    int widths [7] = '{1, 4096, 9, 8191, 0, 3, 2};
    int rows   [7] = '{1, 1, 1, 1, 1, 1, 1};

    initial begin
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        send_idle = 0;
        recv_stall = 0;
        decoder.restart();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed();
        flush_row();
        foreach (widths[s]) begin
            drain();
            write_width(widths[s]);
            set_idle(s);
            for (int r = 0; r < rows[s]; r++) begin
                if (widths[s] == 4096) add_row(4096, 1);
                else if (widths[s] == 0 || widths[s] > 4096) add_header(widths[s]);
                else if ($urandom_range(3) == 0) add_noise(widths[s]);
                else add_row(widths[s], 0);
                send_stream();
            end
            flush_row();
        end
        drain();
        if (decoder.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire
